// ----- sv/stx_etx_frame_receiver_core_macros.svh -----
// assertion macros shared by the frame receiver modules
`ifndef STX_ETX_FRAME_RECEIVER_CORE_MACROS_SVH
`define STX_ETX_FRAME_RECEIVER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define SEFR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sefr check failed");
`define SEFR_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("sefr check failed");
`else
`define SEFR_ASSERT(lbl, prop)
`define SEFR_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ----- sv/sefr_pkg.sv -----
// types, codes and constants of the frame receiver
package sefr_pkg;

  localparam int unsigned FRAME_MAX   = 512;
  localparam int unsigned LIM_W       = 11;
  localparam int unsigned QDEPTH      = 2;
  localparam int unsigned QPTR_W      = $clog2(QDEPTH);
  localparam int unsigned QCNT_W      = $clog2(QDEPTH + 1);
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_EXPECT_ACK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRASH_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LIMIT = 2'd2;

  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_ETX = 8'h03;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_DC2 = 8'h12;
  localparam logic [7:0] CH_DC4 = 8'h14;
  localparam logic [7:0] CH_NAK = 8'h15;

  localparam logic [3:0] ST_NONE     = 4'd0;
  localparam logic [3:0] ST_BYTE     = 4'd1;
  localparam logic [3:0] ST_DC2      = 4'd2;
  localparam logic [3:0] ST_DC4      = 4'd3;
  localparam logic [3:0] ST_ACK      = 4'd4;
  localparam logic [3:0] ST_NAK      = 4'd5;
  localparam logic [3:0] ST_FRAME_OK = 4'd6;
  localparam logic [3:0] ST_FRAME_BAD = 4'd7;
  localparam logic [3:0] ST_TIMEOUT  = 4'd8;
  localparam logic [3:0] ST_TRASH    = 4'd9;
  localparam logic [3:0] ST_OVERFLOW = 4'd10;

  typedef enum logic [2:0] {
    CL_OTHER,
    CL_TIMEOUT,
    CL_STX,
    CL_ETX,
    CL_DC2,
    CL_DC4,
    CL_ACK,
    CL_NAK
  } cls_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic [3:0] status;
    logic [7:0] data_byte;
  } out_word_t;

  typedef struct packed {
    cls_e       cls;
    logic       is_hex;
    logic [3:0] hex_val;
    logic [7:0] data;
  } token_t;

endpackage

// ----- sv/sefr_front.sv -----
// front end: takes words and classifies each into a token
module sefr_front import sefr_pkg::*; (
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_word_t in_word_i,
  input  logic     queue_full_i,
  output logic     push_o,
  output token_t   token_o
);

  logic [7:0] b;
  logic       is_digit;
  logic       is_letter;

  assign b         = in_word_i.rx_byte;
  assign is_digit  = (b >= 8'h30) && (b <= 8'h39);
  // either case of a to f
  assign is_letter = ((b >= 8'h41) && (b <= 8'h46)) || ((b >= 8'h61) && (b <= 8'h66));

  assign in_stall_o = queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i;

  always_comb begin
    token_o.data    = b;
    token_o.is_hex  = !in_word_i.kind && (is_digit || is_letter);
    token_o.hex_val = is_digit ? b[3:0] : 4'(b[3:0] + 4'd9);
    if (in_word_i.kind) begin
      token_o.cls = CL_TIMEOUT;
    end else begin
      case (b)
        CH_STX:  token_o.cls = CL_STX;
        CH_ETX:  token_o.cls = CL_ETX;
        CH_DC2:  token_o.cls = CL_DC2;
        CH_DC4:  token_o.cls = CL_DC4;
        CH_ACK:  token_o.cls = CL_ACK;
        CH_NAK:  token_o.cls = CL_NAK;
        default: token_o.cls = CL_OTHER;
      endcase
    end
  end

endmodule

// ----- sv/sefr_queue.sv -----
// short token queue between front and back
`include "stx_etx_frame_receiver_core_macros.svh"
module sefr_queue import sefr_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  token_t push_token_i,
  input  logic   pop_i,
  output logic   full_o,
  output logic   head_valid_o,
  output token_t head_token_o
);

  token_t            mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  assign full_o       = (count_q == QCNT_W'(QDEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_token_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(wr_ptr_q + 1'b1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(rd_ptr_q + 1'b1);
    end
    case ({push_i, pop_i})
      2'b10:   count_d = QCNT_W'(count_q + 1'b1);
      2'b01:   count_d = QCNT_W'(count_q - 1'b1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_token_i;
    end
  end

  `SEFR_ASSERT_ALWAYS(a_count_bound, !rst_ni || count_q <= QCNT_W'(QDEPTH))
  `SEFR_ASSERT(a_pop_nonempty, pop_i |-> count_q != '0)
  `SEFR_ASSERT(a_empty_ptrs, count_q == '0 |-> wr_ptr_q == rd_ptr_q)

endmodule

// ----- sv/sefr_back.sv -----
// back end: frame state machine, config registers and result register
`include "stx_etx_frame_receiver_core_macros.svh"
module sefr_back import sefr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  head_valid_i,
  input  token_t                head_token_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_word_t             out_word_o
);

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_BODY = 2'd1;
  localparam logic [1:0] PH_SUM  = 2'd2;

  logic                  expect_ack_q;
  logic [7:0]            trash_limit_q;
  logic [CFG_DATA_W-1:0] frame_limit_q;

  logic [1:0]  phase_q, phase_d;
  logic [15:0] sum_q, sum_d;
  logic [9:0]  len_q, len_d;
  logic [1:0]  dcnt_q, dcnt_d;
  logic [15:0] rsum_q, rsum_d;
  logic [7:0]  trash_q, trash_d;
  logic        out_valid_q;
  out_word_t   out_q, res;

  logic [LIM_W-1:0] lim;
  logic             body_ovf;
  logic             stx_ovf;
  logic [15:0]      rsum_new;
  logic [15:0]      sum_add;
  logic             res_term;
  token_t           t;

  assign t     = head_token_i;
  assign pop_o = head_valid_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    lim = {1'b0, frame_limit_q};
    if (lim > LIM_W'(FRAME_MAX)) begin
      lim = LIM_W'(FRAME_MAX);
    end
  end

  assign body_ovf = (LIM_W'(len_q) + LIM_W'(2)) >= lim;
  assign stx_ovf  = LIM_W'(2) >= lim;
  assign rsum_new = {rsum_q[11:0], t.hex_val};
  assign sum_add  = 16'(sum_q + {8'd0, t.data});

  always_comb begin
    phase_d = phase_q;
    sum_d   = sum_q;
    len_d   = len_q;
    dcnt_d  = dcnt_q;
    rsum_d  = rsum_q;
    trash_d = trash_q;
    res     = '{status: ST_NONE, data_byte: 8'd0};
    case (phase_q)
      PH_BODY: begin
        if (t.cls == CL_TIMEOUT) begin
          phase_d    = PH_HUNT;
          trash_d    = '0;
          res.status = ST_TIMEOUT;
        end else if (t.cls == CL_ETX) begin
          sum_d      = sum_add;
          len_d      = 10'(len_q + 1'b1);
          phase_d    = PH_SUM;
          dcnt_d     = '0;
          rsum_d     = '0;
          res        = '{status: ST_BYTE, data_byte: t.data};
        end else if (body_ovf) begin
          phase_d    = PH_HUNT;
          trash_d    = '0;
          res.status = ST_OVERFLOW;
        end else begin
          sum_d      = sum_add;
          len_d      = 10'(len_q + 1'b1);
          res        = '{status: ST_BYTE, data_byte: t.data};
        end
      end
      PH_SUM: begin
        if (!t.is_hex) begin
          // timeout or non-hex digit
          phase_d    = PH_HUNT;
          trash_d    = '0;
          res.status = ST_FRAME_BAD;
        end else begin
          rsum_d = rsum_new;
          if (dcnt_q == 2'd3) begin
            phase_d    = PH_HUNT;
            trash_d    = '0;
            res.status = (rsum_new == sum_q) ? ST_FRAME_OK : ST_FRAME_BAD;
          end else begin
            dcnt_d = 2'(dcnt_q + 1'b1);
          end
        end
      end
      default: begin
        phase_d = PH_HUNT;
        case (t.cls)
          CL_TIMEOUT: begin
            trash_d    = '0;
            res.status = ST_TIMEOUT;
          end
          CL_STX: begin
            dcnt_d = '0;
            rsum_d = '0;
            if (stx_ovf) begin
              sum_d      = '0;
              len_d      = '0;
              trash_d    = '0;
              res.status = ST_OVERFLOW;
            end else begin
              sum_d   = {8'd0, t.data};
              len_d   = 10'd1;
              phase_d = PH_BODY;
              res     = '{status: ST_BYTE, data_byte: t.data};
            end
          end
          CL_DC2: res.status = ST_DC2;
          CL_DC4: res.status = ST_DC4;
          default: begin
            if (expect_ack_q && (t.cls == CL_ACK || t.cls == CL_NAK)) begin
              trash_d    = '0;
              res.status = (t.cls == CL_ACK) ? ST_ACK : ST_NAK;
            end else if (trash_q > trash_limit_q || trash_q == 8'hFF) begin
              trash_d    = '0;
              res.status = ST_TRASH;
            end else begin
              trash_d = 8'(trash_q + 1'b1);
            end
          end
        endcase
      end
    endcase
  end

  assign res_term = (res.status == ST_ACK) || (res.status == ST_NAK) ||
                    (res.status == ST_FRAME_OK) || (res.status == ST_FRAME_BAD) ||
                    (res.status == ST_TIMEOUT) || (res.status == ST_TRASH) ||
                    (res.status == ST_OVERFLOW);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_ack_q  <= 1'b0;
      trash_limit_q <= 8'd32;
      frame_limit_q <= CFG_DATA_W'(FRAME_MAX);
      phase_q       <= PH_HUNT;
      sum_q         <= '0;
      len_q         <= '0;
      dcnt_q        <= '0;
      rsum_q        <= '0;
      trash_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_EXPECT_ACK:  expect_ack_q  <= cfg_data_i[0];
          CFG_TRASH_LIMIT: trash_limit_q <= cfg_data_i[7:0];
          CFG_FRAME_LIMIT: frame_limit_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (pop_o) begin
        phase_q     <= phase_d;
        sum_q       <= sum_d;
        len_q       <= len_d;
        dcnt_q      <= dcnt_d;
        rsum_q      <= rsum_d;
        trash_q     <= trash_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  `SEFR_ASSERT(a_data_only_stored, out_valid_q && out_q.status != ST_BYTE |-> out_q.data_byte == 8'd0)
  `SEFR_ASSERT(a_term_hunts, pop_o && res_term |=> phase_q == PH_HUNT && trash_q == 8'd0)
  `SEFR_ASSERT(a_sum_after_etx, $rose(phase_q == PH_SUM) |-> out_valid_q && out_q.data_byte == CH_ETX)

endmodule

// ----- sv/stx_etx_frame_receiver_core.sv -----
// top level of the stx/etx frame receiver
//
//   channel  direction  handshake                  word
//   in       input      in_valid_i / in_stall_o    in_word_t  (kind, rx_byte)
//   out      output     out_valid_o / out_stall_i  out_word_t (status, data_byte)
//   cfg      input      cfg_we_i, cfg_index_i      cfg_data_i
//
// one word per cycle sustained while out_stall_i is low; a taken word is registered in
// the token queue, its result in the result register (front classifies into a two-entry
// token queue, back updates the frame state); every word gives exactly one result
// asynchronous active-low reset returns to hunting with default config, no clearing pass
// in_stall_o is high only while the token queue is full; out_stall_i holds the result
module stx_etx_frame_receiver_core import sefr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_word_t              in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_word_t             out_word_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic   queue_full;
  logic   push;
  logic   pop;
  logic   head_valid;
  token_t push_token;
  token_t head_token;

  sefr_front u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .queue_full_i(queue_full),
    .push_o      (push),
    .token_o     (push_token)
  );

  sefr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_token_i(push_token),
    .pop_i       (pop),
    .full_o      (queue_full),
    .head_valid_o(head_valid),
    .head_token_o(head_token)
  );

  sefr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .head_valid_i(head_valid),
    .head_token_i(head_token),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule
